// ===== rtl/vbi_line_source_scheduler_unit_assert.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef VBI_LINE_SOURCE_SCHEDULER_UNIT_ASSERT_SVH
`define VBI_LINE_SOURCE_SCHEDULER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VLSS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define VLSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ===== rtl/vlss_pkg.sv =====
// Types and constants shared by the VBI line source scheduler modules.
package vlss_pkg;

    typedef enum logic [2:0] {
        KIND_BSDP  = 3'd0,
        KIND_DEBUG = 3'd1,
        KIND_DC    = 3'd2,
        KIND_MAG   = 3'd3,
        KIND_FILL  = 3'd4
    } kind_t;

    localparam logic [7:0] REG_LINES_PER_FIELD = 8'd0;
    localparam logic [7:0] REG_DATACAST_LINES  = 8'd1;

    localparam logic [7:0] LINES_PER_FIELD_RESET = 8'd16;
    localparam logic [7:0] DATACAST_LINES_RESET  = 8'd0;

    localparam logic [5:0] LAST_FIELD      = 6'd49;
    localparam logic [3:0] LAST_SECOND     = 4'd14;
    localparam int         BSDP_FIELD_STEP = 10;

    localparam int MAG_IW = 3;
    localparam int DC_IW  = 4;

    typedef struct packed {
        logic [7:0] line_number;
        logic [5:0] field_number;
        logic       field_start;
        logic       special_event;
        logic [2:0] bsdp_event;
        logic       datacast_window;
    } timing_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] index;
    } sel_t;

endpackage

// ===== rtl/vlss_counters.sv =====
// Line, field and seconds counters with slot events and a line wrap divider.
module vlss_counters (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             lpf_write,
    input  logic [7:0]       lines_per_field,
    input  logic [7:0]       datacast_lines,
    output logic             busy,
    output vlss_pkg::timing_t timing
);
    import vlss_pkg::*;

    localparam logic [3:0] DIV_LAST = 4'd8;

    logic [7:0] line_reg, line_next;
    logic [5:0] field_reg, field_next;
    logic [3:0] sec_reg, sec_next;
    logic       first_reg, first_next;
    logic       div_busy_reg, div_busy_next;
    logic [3:0] div_cnt_reg, div_cnt_next;
    logic [8:0] div_dvd_reg, div_dvd_next;
    logic [8:0] div_rem_reg, div_rem_next;
    logic       preset_reg, preset_next;

    logic [8:0] line_plus;
    logic [8:0] shifted;
    logic [7:0] line_new;
    logic       fstart;
    logic [5:0] field_new;
    logic [3:0] sec_new;
    logic [2:0] bsdp_ev;
    logic       window;

    assign line_plus = {1'b0, line_reg} + 9'd1;
    assign shifted   = {div_rem_reg[7:0], div_dvd_reg[8]};

    always_comb begin
        if (first_reg || lines_per_field == 8'd0) begin
            line_new = 8'd0;
        end else if (preset_reg) begin
            line_new = div_rem_reg[7:0];
        end else if (line_plus >= {1'b0, lines_per_field}) begin
            line_new = 8'd0;
        end else begin
            line_new = line_plus[7:0];
        end
    end

    assign fstart = (line_new == 8'd0);

    always_comb begin
        field_new = field_reg;
        sec_new   = sec_reg;
        if (fstart) begin
            field_new = (field_reg == LAST_FIELD) ? 6'd0 : field_reg + 6'd1;
            if (field_new == 6'd0) begin
                sec_new = (sec_reg == LAST_SECOND) ? 4'd0 : sec_reg + 4'd1;
            end
        end
    end

    always_comb begin
        unique case (field_new)
            6'(0 * BSDP_FIELD_STEP): bsdp_ev = 3'd1;
            6'(1 * BSDP_FIELD_STEP): bsdp_ev = 3'd2;
            6'(2 * BSDP_FIELD_STEP): bsdp_ev = 3'd3;
            6'(3 * BSDP_FIELD_STEP): bsdp_ev = 3'd4;
            6'(4 * BSDP_FIELD_STEP): bsdp_ev = 3'd5;
            default:                 bsdp_ev = 3'd0;
        endcase
        if (!fstart) begin
            bsdp_ev = 3'd0;
        end
    end

    assign window = (datacast_lines == 8'd0) ||
                    ($signed({2'b00, line_new}) >=
                     $signed({2'b00, lines_per_field}) - $signed({2'b00, datacast_lines}));

    always_comb begin
        line_next     = line_reg;
        field_next    = field_reg;
        sec_next      = sec_reg;
        first_next    = first_reg;
        preset_next   = preset_reg;
        div_busy_next = div_busy_reg;
        div_cnt_next  = div_cnt_reg;
        div_dvd_next  = div_dvd_reg;
        div_rem_next  = div_rem_reg;
        if (lpf_write) begin
            div_busy_next = 1'b1;
            div_cnt_next  = 4'd0;
            div_dvd_next  = line_plus;
            div_rem_next  = 9'd0;
            preset_next   = 1'b0;
        end else if (div_busy_reg) begin
            div_dvd_next = {div_dvd_reg[7:0], 1'b0};
            div_rem_next = (shifted >= {1'b0, lines_per_field}) ?
                           shifted - {1'b0, lines_per_field} : shifted;
            div_cnt_next = div_cnt_reg + 4'd1;
            if (div_cnt_reg == DIV_LAST) begin
                div_busy_next = 1'b0;
                preset_next   = 1'b1;
            end
        end else if (step) begin
            line_next   = line_new;
            field_next  = field_new;
            sec_next    = sec_new;
            first_next  = 1'b0;
            preset_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg     <= 8'd0;
            field_reg    <= LAST_FIELD;
            sec_reg      <= 4'd0;
            first_reg    <= 1'b1;
            preset_reg   <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= 4'd0;
        end else begin
            line_reg     <= line_next;
            field_reg    <= field_next;
            sec_reg      <= sec_next;
            first_reg    <= first_next;
            preset_reg   <= preset_next;
            div_busy_reg <= div_busy_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_dvd_reg <= div_dvd_next;
        div_rem_reg <= div_rem_next;
    end

    assign busy = div_busy_reg;

    always_comb begin
        timing.line_number     = line_new;
        timing.field_number    = field_new;
        timing.field_start     = fstart;
        timing.special_event   = fstart && (field_new == 6'd0) && (sec_new == 4'd0);
        timing.bsdp_event      = bsdp_ev;
        timing.datacast_window = window;
    end

endmodule

// ===== rtl/vlss_select.sv =====
// Source selection with round robin pointers for magazines and datacast channels.
module vlss_select #(
    parameter int NUM_MAGAZINES = 8,
    parameter int NUM_DATACAST  = 15
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic            dc_reserved,
    input  logic            bsdp_ready,
    input  logic            bsdp_valid,
    input  logic            debug_ready,
    input  logic [14:0]     dc_ready,
    input  logic [14:0]     dc_ready_forced,
    input  logic [7:0]      mag_ready,
    input  logic [7:0]      mag_ready_forced,
    input  logic [7:0]      mag_valid,
    output vlss_pkg::sel_t  sel
);
    import vlss_pkg::*;

    localparam int MAG_PW = (NUM_MAGAZINES > 1) ? $clog2(NUM_MAGAZINES) : 1;
    localparam int DC_PW  = (NUM_DATACAST > 1) ? $clog2(NUM_DATACAST) : 1;

    function automatic logic [MAG_PW-1:0] mag_wrap(input logic [MAG_PW:0] v);
        logic [MAG_PW:0] w;
        w = (v >= (MAG_PW+1)'(NUM_MAGAZINES)) ? v - (MAG_PW+1)'(NUM_MAGAZINES) : v;
        return w[MAG_PW-1:0];
    endfunction

    function automatic logic [DC_PW-1:0] dc_wrap(input logic [DC_PW:0] v);
        logic [DC_PW:0] w;
        w = (v >= (DC_PW+1)'(NUM_DATACAST)) ? v - (DC_PW+1)'(NUM_DATACAST) : v;
        return w[DC_PW-1:0];
    endfunction

    logic [MAG_PW-1:0] mag_ptr_reg, mag_ptr_next;
    logic [DC_PW-1:0]  dc_ptr_reg, dc_ptr_next;

    logic              mag_hit;
    logic [MAG_PW-1:0] mag_hit_pos;
    logic [MAG_IW-1:0] mag_num;
    logic [MAG_PW-1:0] mag_ptr_upd;
    logic              dc_hit;
    logic [DC_PW-1:0]  dc_hit_pos;
    logic [DC_IW-1:0]  dc_chan;
    logic [DC_PW-1:0]  dc_ptr_upd;
    logic              mag_take;
    logic              dc_take;

    always_comb begin
        logic [MAG_PW-1:0] pos;
        mag_hit     = 1'b0;
        mag_hit_pos = mag_ptr_reg;
        for (int k = NUM_MAGAZINES; k >= 1; k--) begin
            pos = mag_wrap({1'b0, mag_ptr_reg} + (MAG_PW+1)'(k));
            if (mag_ready_forced[MAG_IW'(NUM_MAGAZINES - 1) - MAG_IW'(pos)]) begin
                mag_hit     = 1'b1;
                mag_hit_pos = pos;
            end
        end
        for (int k = NUM_MAGAZINES - 1; k >= 0; k--) begin
            pos = mag_wrap({1'b0, mag_ptr_reg} + (MAG_PW+1)'(k));
            if (mag_ready[MAG_IW'(NUM_MAGAZINES - 1) - MAG_IW'(pos)]) begin
                mag_hit     = 1'b1;
                mag_hit_pos = pos;
            end
        end
    end

    assign mag_num     = MAG_IW'(NUM_MAGAZINES - 1) - MAG_IW'(mag_hit_pos);
    assign mag_ptr_upd = mag_hit ? mag_wrap({1'b0, mag_hit_pos} + (MAG_PW+1)'(1)) :
                                   mag_wrap({1'b0, mag_ptr_reg} + (MAG_PW+1)'(1));

    always_comb begin
        logic [DC_PW-1:0] pos;
        logic [DC_IW-1:0] bit_idx;
        logic             rdy;
        dc_hit     = 1'b0;
        dc_hit_pos = dc_ptr_reg;
        for (int c = NUM_DATACAST - 1; c >= 0; c--) begin
            pos     = dc_wrap({1'b0, dc_ptr_reg} + (DC_PW+1)'(c));
            bit_idx = DC_IW'(NUM_DATACAST - 1) - DC_IW'(pos);
            rdy     = (dc_reserved && c == NUM_DATACAST - 1) ? dc_ready_forced[bit_idx] :
                                                               dc_ready[bit_idx];
            if (rdy) begin
                dc_hit     = 1'b1;
                dc_hit_pos = pos;
            end
        end
    end

    assign dc_chan    = DC_IW'(NUM_DATACAST) - DC_IW'(dc_hit_pos);
    assign dc_ptr_upd = dc_wrap({1'b0, dc_hit_pos} + (DC_PW+1)'(1));

    always_comb begin
        sel.kind  = KIND_FILL;
        sel.index = 4'd0;
        mag_take  = 1'b0;
        dc_take   = 1'b0;
        priority if (bsdp_ready) begin
            sel.kind = bsdp_valid ? KIND_BSDP : KIND_FILL;
        end else if (debug_ready) begin
            sel.kind = KIND_DEBUG;
        end else if (dc_reserved && dc_hit) begin
            sel.kind  = KIND_DC;
            sel.index = dc_chan;
            dc_take   = 1'b1;
        end else begin
            mag_take = 1'b1;
            if (mag_hit && mag_valid[mag_num]) begin
                sel.kind  = KIND_MAG;
                sel.index = 4'(mag_num);
            end else if (!dc_reserved && dc_hit) begin
                sel.kind  = KIND_DC;
                sel.index = dc_chan;
                dc_take   = 1'b1;
            end
        end
    end

    always_comb begin
        mag_ptr_next = mag_ptr_reg;
        dc_ptr_next  = dc_ptr_reg;
        if (step && mag_take) begin
            mag_ptr_next = mag_ptr_upd;
        end
        if (step && dc_take) begin
            dc_ptr_next = dc_ptr_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_ptr_reg <= '0;
            dc_ptr_reg  <= '0;
        end else begin
            mag_ptr_reg <= mag_ptr_next;
            dc_ptr_reg  <= dc_ptr_next;
        end
    end

endmodule

// ===== rtl/vbi_line_source_scheduler_unit.sv =====
// Top level of the VBI line source scheduler: handshakes, configuration and result register.
//
// One input word describes one VBI line slot and yields exactly one result word. The word
// passes through an input register, one stage of counter and selection logic, and an output
// register, and a new slot is taken every cycle while the result side keeps up and no divider
// run is in progress. Writing lines_per_field starts a divider that refolds the line counter
// onto the new field length; slots wait in the input register until it finishes.
// Configuration writes are always accepted.
`include "vbi_line_source_scheduler_unit_assert.svh"

module vbi_line_source_scheduler_unit #(
    parameter int NUM_MAGAZINES = 8,
    parameter int NUM_DATACAST  = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_bsdp_ready,
    input  logic        s_bsdp_valid,
    input  logic        s_debug_ready,
    input  logic [14:0] s_dc_ready,
    input  logic [14:0] s_dc_ready_forced,
    input  logic [7:0]  s_mag_ready,
    input  logic [7:0]  s_mag_ready_forced,
    input  logic [7:0]  s_mag_valid,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_source_kind,
    output logic [3:0]  m_source_index,
    output logic [7:0]  m_line_number,
    output logic [5:0]  m_field_number,
    output logic        m_field_start,
    output logic        m_special_event,
    output logic [2:0]  m_bsdp_event,
    output logic        m_datacast_window
);
    import vlss_pkg::*;

    logic [7:0]  lpf_reg, lpf_next;
    logic [7:0]  dcl_reg, dcl_next;
    logic        cfg_write;
    logic        lpf_write;

    logic        in_valid_reg, in_valid_next;
    logic        in_bsdp_ready_reg;
    logic        in_bsdp_valid_reg;
    logic        in_debug_ready_reg;
    logic [14:0] in_dc_ready_reg;
    logic [14:0] in_dc_ready_forced_reg;
    logic [7:0]  in_mag_ready_reg;
    logic [7:0]  in_mag_ready_forced_reg;
    logic [7:0]  in_mag_valid_reg;

    logic        out_valid_reg, out_valid_next;
    sel_t        out_sel_reg;
    timing_t     out_timing_reg;

    logic        busy;
    logic        advance;
    logic        in_take;
    timing_t     timing;
    sel_t        sel;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign lpf_write = cfg_write && (cfg_index == REG_LINES_PER_FIELD);

    always_comb begin
        lpf_next = lpf_reg;
        dcl_next = dcl_reg;
        if (cfg_write) begin
            if (cfg_index == REG_LINES_PER_FIELD) begin
                lpf_next = cfg_data;
            end else if (cfg_index == REG_DATACAST_LINES) begin
                dcl_next = cfg_data;
            end
        end
    end

    assign advance = in_valid_reg && !busy && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lpf_reg       <= LINES_PER_FIELD_RESET;
            dcl_reg       <= DATACAST_LINES_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            lpf_reg       <= lpf_next;
            dcl_reg       <= dcl_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_bsdp_ready_reg       <= s_bsdp_ready;
            in_bsdp_valid_reg       <= s_bsdp_valid;
            in_debug_ready_reg      <= s_debug_ready;
            in_dc_ready_reg         <= s_dc_ready;
            in_dc_ready_forced_reg  <= s_dc_ready_forced;
            in_mag_ready_reg        <= s_mag_ready;
            in_mag_ready_forced_reg <= s_mag_ready_forced;
            in_mag_valid_reg        <= s_mag_valid;
        end
        if (advance) begin
            out_sel_reg    <= sel;
            out_timing_reg <= timing;
        end
    end

    vlss_counters u_counters (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .lpf_write       (lpf_write),
        .lines_per_field (lpf_reg),
        .datacast_lines  (dcl_reg),
        .busy            (busy),
        .timing          (timing)
    );

    vlss_select #(
        .NUM_MAGAZINES (NUM_MAGAZINES),
        .NUM_DATACAST  (NUM_DATACAST)
    ) u_select (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (advance),
        .dc_reserved      (dcl_reg != 8'd0),
        .bsdp_ready       (in_bsdp_ready_reg),
        .bsdp_valid       (in_bsdp_valid_reg),
        .debug_ready      (in_debug_ready_reg),
        .dc_ready         (in_dc_ready_reg),
        .dc_ready_forced  (in_dc_ready_forced_reg),
        .mag_ready        (in_mag_ready_reg),
        .mag_ready_forced (in_mag_ready_forced_reg),
        .mag_valid        (in_mag_valid_reg),
        .sel              (sel)
    );

    assign m_valid           = out_valid_reg;
    assign m_source_kind     = out_sel_reg.kind;
    assign m_source_index    = out_sel_reg.index;
    assign m_line_number     = out_timing_reg.line_number;
    assign m_field_number    = out_timing_reg.field_number;
    assign m_field_start     = out_timing_reg.field_start;
    assign m_special_event   = out_timing_reg.special_event;
    assign m_bsdp_event      = out_timing_reg.bsdp_event;
    assign m_datacast_window = out_timing_reg.datacast_window;

    `VLSS_ASSERT_NEXT(a_lpf_write_holds_slots, aclk, aresetn, lpf_write, busy && !advance)
    `VLSS_ASSERT_SAME(a_field_start_line_zero, aclk, aresetn, m_valid,
        m_field_start == (m_line_number == 8'd0))
    `VLSS_ASSERT_SAME(a_special_on_field_zero, aclk, aresetn, m_valid && m_special_event,
        m_field_start && m_field_number == 6'd0 && m_bsdp_event == 3'd1)
    `VLSS_ASSERT_SAME(a_index_only_for_channels, aclk, aresetn,
        m_valid && m_source_kind != KIND_DC && m_source_kind != KIND_MAG,
        m_source_index == 4'd0)

endmodule
